>>> rtl/core/mdct_pkg.sv
package mdct_pkg;

  localparam int unsigned MIN_OFF_SECONDS        = 3;
  localparam int unsigned MIN_ON_SECONDS         = 3;
  localparam int unsigned COAST_SECONDS          = 10;
  localparam int unsigned ADAPTIVE_LIMIT_SECONDS = 60;
  localparam int unsigned LONG_CYCLE_SECONDS     = 30;

  localparam int unsigned MS_PER_SECOND = 1000;
  localparam int unsigned FULL_WATTS    = 700;

  // Division by FULL_WATTS as a multiply by a rounded-up reciprocal.
  // The error term stays below one for every 18-bit dividend.
  localparam int unsigned DIV_SHIFT = 27;
  localparam int unsigned DIV_MULT  = ((1 << DIV_SHIFT) + FULL_WATTS - 1) / FULL_WATTS;

  localparam logic [9:0] LEVEL_WATTS_RESET = 10'(FULL_WATTS);

  typedef enum logic [1:0] {
    ACT_START  = 2'd0,
    ACT_RESUME = 2'd1,
    ACT_TICK   = 2'd2
  } mdct_action_e;

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_COOKING  = 2'd1,
    PH_STAGE2   = 2'd2,
    PH_FINISHED = 2'd3
  } mdct_phase_e;

  typedef enum logic [1:0] {
    MELODY_NONE   = 2'd0,
    MELODY_STAGE1 = 2'd1,
    MELODY_FINAL  = 2'd2
  } mdct_melody_e;

  typedef enum logic [1:0] {
    REG_POWER_LEVEL    = 2'd0,
    REG_LEVEL_WATTS    = 2'd1,
    REG_STAGE2_SECONDS = 2'd2
  } mdct_reg_e;

  typedef struct packed {
    logic        mag;
    logic [31:0] last_off;
  } mdct_drive_t;

endpackage

>>> rtl/core/mdct_cfg_if.sv
interface mdct_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/core/mdct_in_if.sv
interface mdct_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic        door_closed;
  logic [31:0] now_ms;
  logic [15:0] cook_seconds;
  logic        stage1_melody_idle;
  logic        final_melody_idle;

  modport source (output valid, action, door_closed, now_ms, cook_seconds,
                  stage1_melody_idle, final_melody_idle, input ready);
  modport sink (input valid, action, door_closed, now_ms, cook_seconds,
                stage1_melody_idle, final_melody_idle, output ready);
endinterface

>>> rtl/core/mdct_out_if.sv
interface mdct_out_if;
  logic        valid;
  logic        ready;
  logic        magnetron_on;
  logic        fan_on;
  logic [1:0]  cook_state;
  logic [15:0] seconds_left;
  logic        start_refused;
  logic [1:0]  melody_start;
  logic        flip_check;

  modport source (output valid, magnetron_on, fan_on, cook_state, seconds_left,
                  start_refused, melody_start, flip_check, input ready);
  modport sink (input valid, magnetron_on, fan_on, cook_state, seconds_left,
                start_refused, melody_start, flip_check, output ready);
endinterface

>>> rtl/core/mdct_on_time.sv
module mdct_on_time #(
  parameter int unsigned MIN_OFF_SECONDS        = mdct_pkg::MIN_OFF_SECONDS,
  parameter int unsigned MIN_ON_SECONDS         = mdct_pkg::MIN_ON_SECONDS,
  parameter int unsigned COAST_SECONDS          = mdct_pkg::COAST_SECONDS,
  parameter int unsigned ADAPTIVE_LIMIT_SECONDS = mdct_pkg::ADAPTIVE_LIMIT_SECONDS,
  parameter int unsigned LONG_CYCLE_SECONDS     = mdct_pkg::LONG_CYCLE_SECONDS
) (
  input  logic        clk_i,
  input  logic        load_i,
  input  logic [15:0] cook_seconds_i,
  input  logic [3:0]  power_level_i,
  input  logic [9:0]  level_watts_i,
  output logic [7:0]  cycle_length_o,
  output logic [7:0]  on_seconds_o
);

  localparam logic [35:0] DivMult = 36'(mdct_pkg::DIV_MULT);

  logic [7:0]  cyc_d, cyc_q;
  logic [17:0] prod_d, prod_q;
  logic        full_q;
  logic [35:0] recip;
  logic [8:0]  quot;
  logic [7:0]  max_on;
  logic [8:0]  t;

  // The cycle length and the watts product are formed as the beat is taken.
  always_comb begin
    if ((cook_seconds_i < 16'(COAST_SECONDS) && power_level_i != 4'd0) ||
        cook_seconds_i < 16'(ADAPTIVE_LIMIT_SECONDS)) begin
      cyc_d = cook_seconds_i[7:0];
    end else begin
      cyc_d = 8'(LONG_CYCLE_SECONDS);
    end
    prod_d = 18'(level_watts_i) * 18'(cyc_d);
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      cyc_q  <= cyc_d;
      prod_q <= prod_d;
      full_q <= (power_level_i == 4'd0);
    end
  end

  always_comb begin
    recip  = 36'(prod_q) * DivMult;
    quot   = recip[mdct_pkg::DIV_SHIFT +: 9];
    max_on = (cyc_q > 8'(MIN_OFF_SECONDS)) ? cyc_q - 8'(MIN_OFF_SECONDS) : 8'd0;
    t      = quot;
    if (9'(MIN_ON_SECONDS) > {1'b0, max_on}) begin
      t = {1'b0, max_on};
    end else begin
      if (t < 9'(MIN_ON_SECONDS)) begin
        t = 9'(MIN_ON_SECONDS);
      end
      if (t > {1'b0, max_on}) begin
        t = {1'b0, max_on};
      end
    end
    on_seconds_o   = full_q ? cyc_q : t[7:0];
    cycle_length_o = cyc_q;
  end

endmodule

>>> rtl/core/magnetron_duty_cook_timer_unit.sv
// Cook timer with slow time-proportional magnetron control. Each beat on the
// input channel is a start, a resume or a one-second tick; each gives exactly one
// result beat. A beat is taken into an input register, and the result is then
// registered in the output register, so the block takes one beat per cycle when
// the output side is not stalled. The on-time multiply is formed as the beat is
// taken, and its division by the full-power wattage is done on the registered
// product together with the state update.
// Configuration writes take effect at once and are meant for idle periods.
module magnetron_duty_cook_timer_unit #(
  parameter int unsigned MIN_OFF_SECONDS        = mdct_pkg::MIN_OFF_SECONDS,
  parameter int unsigned MIN_ON_SECONDS         = mdct_pkg::MIN_ON_SECONDS,
  parameter int unsigned COAST_SECONDS          = mdct_pkg::COAST_SECONDS,
  parameter int unsigned ADAPTIVE_LIMIT_SECONDS = mdct_pkg::ADAPTIVE_LIMIT_SECONDS,
  parameter int unsigned LONG_CYCLE_SECONDS     = mdct_pkg::LONG_CYCLE_SECONDS
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  mdct_cfg_if.sink   cfg_i,
  mdct_in_if.sink    in_i,
  mdct_out_if.source out_o
);

  localparam logic [31:0] MinOffMs = 32'(MIN_OFF_SECONDS * mdct_pkg::MS_PER_SECOND);

  logic [3:0]  power_level_q;
  logic [9:0]  level_watts_q;
  logic [15:0] stage2_q;

  logic        in_valid_q;
  logic [1:0]  action_q;
  logic        door_q;
  logic [31:0] now_q;
  logic [15:0] cook_q;
  logic        s1_idle_q;
  logic        fin_idle_q;

  logic                  mag_q, mag_d;
  logic [31:0]           last_off_q, last_off_d;
  mdct_pkg::mdct_phase_e phase_q, phase_d;
  logic [15:0]           rem_q, rem_d;
  logic [15:0]           tot_q, tot_d;
  logic [7:0]            cyc_q, cyc_d;
  logic [7:0]            on_q, on_d;
  logic [7:0]            pos_q, pos_d;
  logic                  fan_q, fan_d;

  logic                   refused;
  mdct_pkg::mdct_melody_e melody;
  logic                   flip;

  logic        out_valid_q;
  logic        out_mag_q;
  logic        out_fan_q;
  logic [1:0]  out_state_q;
  logic [15:0] out_left_q;
  logic        out_refused_q;
  logic [1:0]  out_melody_q;
  logic        out_flip_q;

  logic       in_fire;
  logic       advance;
  logic [7:0] calc_cyc;
  logic [7:0] calc_on;

  assign advance  = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;
  assign in_fire  = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      power_level_q <= 4'd0;
      level_watts_q <= mdct_pkg::LEVEL_WATTS_RESET;
      stage2_q      <= 16'd0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        mdct_pkg::REG_POWER_LEVEL:    power_level_q <= cfg_i.data[3:0];
        mdct_pkg::REG_LEVEL_WATTS:    level_watts_q <= cfg_i.data[9:0];
        mdct_pkg::REG_STAGE2_SECONDS: stage2_q      <= cfg_i.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      action_q   <= in_i.action;
      door_q     <= in_i.door_closed;
      now_q      <= in_i.now_ms;
      cook_q     <= in_i.cook_seconds;
      s1_idle_q  <= in_i.stage1_melody_idle;
      fin_idle_q <= in_i.final_melody_idle;
    end
  end

  mdct_on_time #(
    .MIN_OFF_SECONDS        (MIN_OFF_SECONDS),
    .MIN_ON_SECONDS         (MIN_ON_SECONDS),
    .COAST_SECONDS          (COAST_SECONDS),
    .ADAPTIVE_LIMIT_SECONDS (ADAPTIVE_LIMIT_SECONDS),
    .LONG_CYCLE_SECONDS     (LONG_CYCLE_SECONDS)
  ) u_on_time (
    .clk_i          (clk_i),
    .load_i         (in_fire),
    .cook_seconds_i (in_i.cook_seconds),
    .power_level_i  (power_level_q),
    .level_watts_i  (level_watts_q),
    .cycle_length_o (calc_cyc),
    .on_seconds_o   (calc_on)
  );

  // Switching on is held off until the minimum off time has passed since the
  // last switch-off; a stored time of zero means it was never switched off.
  function automatic mdct_pkg::mdct_drive_t drive(input logic on, input logic [31:0] now,
                                                  input mdct_pkg::mdct_drive_t cur);
    mdct_pkg::mdct_drive_t nxt;
    logic [31:0]           elapsed;
    nxt     = cur;
    elapsed = now - cur.last_off;
    if (on) begin
      if (!(cur.last_off != 32'd0 && elapsed < MinOffMs)) begin
        nxt.mag = 1'b1;
      end
    end else begin
      if (cur.mag) begin
        nxt.last_off = now;
      end
      nxt.mag = 1'b0;
    end
    return nxt;
  endfunction

  always_comb begin
    mdct_pkg::mdct_drive_t dv;
    logic                  want;
    logic [8:0]            pos_inc;
    dv         = '{mag: mag_q, last_off: last_off_q};
    phase_d    = phase_q;
    rem_d      = rem_q;
    tot_d      = tot_q;
    cyc_d      = cyc_q;
    on_d       = on_q;
    pos_d      = pos_q;
    fan_d      = fan_q;
    refused    = 1'b0;
    melody     = mdct_pkg::MELODY_NONE;
    flip       = 1'b0;
    want       = 1'b0;
    pos_inc    = 9'd0;
    case (action_q)
      mdct_pkg::ACT_START: begin
        if (!door_q) begin
          refused = 1'b1;
        end else begin
          fan_d   = 1'b1;
          tot_d   = cook_q;
          rem_d   = cook_q;
          cyc_d   = calc_cyc;
          on_d    = calc_on;
          pos_d   = 8'd0;
          dv      = drive(1'b1, now_q, dv);
          phase_d = mdct_pkg::PH_COOKING;
        end
      end
      mdct_pkg::ACT_RESUME: begin
        if (door_q) begin
          phase_d = mdct_pkg::PH_COOKING;
          fan_d   = 1'b1;
          want    = pos_q < on_q;
          if (want && tot_q >= 16'(ADAPTIVE_LIMIT_SECONDS) &&
              rem_q < 16'(COAST_SECONDS) && power_level_q != 4'd0) begin
            dv = drive(1'b0, now_q, dv);
          end else begin
            dv = drive(want, now_q, dv);
          end
        end
      end
      mdct_pkg::ACT_TICK: begin
        if (phase_q == mdct_pkg::PH_COOKING && rem_q != 16'd0) begin
          if (rem_q == 16'd3) begin
            if (stage2_q != 16'd0) begin
              if (s1_idle_q) begin
                melody = mdct_pkg::MELODY_STAGE1;
              end
            end else if (fin_idle_q) begin
              melody = mdct_pkg::MELODY_FINAL;
            end
          end
          rem_d = rem_q - 16'd1;
          flip  = 1'b1;
          want  = pos_q < on_q;
          if (want && tot_q >= 16'(ADAPTIVE_LIMIT_SECONDS) &&
              rem_d < 16'(COAST_SECONDS) && power_level_q != 4'd0) begin
            dv = drive(1'b0, now_q, dv);
          end else begin
            dv = drive(want, now_q, dv);
          end
          pos_inc = {1'b0, pos_q} + 9'd1;
          pos_d   = (pos_inc >= {1'b0, cyc_q}) ? 8'd0 : pos_inc[7:0];
          if (rem_d == 16'd0) begin
            phase_d = (stage2_q != 16'd0) ? mdct_pkg::PH_STAGE2 : mdct_pkg::PH_FINISHED;
            dv      = drive(1'b0, now_q, dv);
            fan_d   = 1'b0;
          end
        end
      end
      default: ;
    endcase
    mag_d      = dv.mag;
    last_off_d = dv.last_off;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mag_q      <= 1'b0;
      last_off_q <= 32'd0;
      phase_q    <= mdct_pkg::PH_IDLE;
      rem_q      <= 16'd0;
      tot_q      <= 16'd0;
      cyc_q      <= 8'd0;
      on_q       <= 8'd0;
      pos_q      <= 8'd0;
      fan_q      <= 1'b0;
    end else if (advance) begin
      mag_q      <= mag_d;
      last_off_q <= last_off_d;
      phase_q    <= phase_d;
      rem_q      <= rem_d;
      tot_q      <= tot_d;
      cyc_q      <= cyc_d;
      on_q       <= on_d;
      pos_q      <= pos_d;
      fan_q      <= fan_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_mag_q     <= mag_d;
      out_fan_q     <= fan_d;
      out_state_q   <= phase_d;
      out_left_q    <= rem_d;
      out_refused_q <= refused;
      out_melody_q  <= melody;
      out_flip_q    <= flip;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.magnetron_on  = out_mag_q;
  assign out_o.fan_on        = out_fan_q;
  assign out_o.cook_state    = out_state_q;
  assign out_o.seconds_left  = out_left_q;
  assign out_o.start_refused = out_refused_q;
  assign out_o.melody_start  = out_melody_q;
  assign out_o.flip_check    = out_flip_q;

`ifndef ASSERT_OFF
  // The magnetron never runs without the fan.
  a_mag_needs_fan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mag_q |-> fan_q)
    else $error("magnetron on while fan is off");

  a_pos_in_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pos_q < cyc_q) || (pos_q == 8'd0))
    else $error("cycle position beyond cycle length");

  a_on_in_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    on_q <= cyc_q)
    else $error("on time exceeds cycle length");

  a_flip_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && flip) |=> (rem_q == $past(rem_q) - 16'd1))
    else $error("tick did not count down by one second");
`endif

endmodule
